// ===== src/sha1s_pkg.sv =====
// shared types, codes and constants for the streaming sha-1 hash block
// no dependencies; imported by every module under src
`timescale 1ns / 1ps

package sha1s_pkg;

    // input beat: one message byte or an end-of-message mark
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    // output beat: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } result_t;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // ops carried from the front end to the compression core
    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] value;
    } qent_t;

    typedef struct packed {
        logic  push;
        qent_t ent;
    } qpush_t;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_WORDS  = 16;

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] LAST_POS    = 6'd63;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [2:0] LAST_INDEX  = 3'd4;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0:    h = 32'h67452301;
            3'd1:    h = 32'hEFCDAB89;
            3'd2:    h = 32'h98BADCFE;
            3'd3:    h = 32'h10325476;
            default: h = 32'hC3D2E1F0;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        priority if (r < 7'd20) k = 32'h5A827999;
        else if (r < 7'd40)     k = 32'h6ED9EBA1;
        else if (r < 7'd60)     k = 32'h8F1BBCDC;
        else                    k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        priority if (r < 7'd20) f = (b & c) | (~b & d);
        else if (r < 7'd40)     f = b ^ c ^ d;
        else if (r < 7'd60)     f = (b & c) | (b & d) | (c & d);
        else                    f = b ^ c ^ d;
        return f;
    endfunction

endpackage

// ===== src/sha1_stream_hash.sv =====
// top level of the streaming sha-1 hash: front end, op queue, compression core
// depends on sha1s_pkg, sha1s_front, sha1s_fifo, sha1s_core
//
//  channel  | valid        | stall        | payload           | per beat
//  ---------+--------------+--------------+-------------------+---------------------------
//  item     | item_valid   | item_stall   | item   (item_t)   | one byte or an end mark
//  digest   | digest_valid | digest_stall | digest (result_t) | one digest word, 5 per end
//
// data bytes go in one per cycle until the 4-entry queue fills; the core drains one byte
// per cycle while idle or in the chain add, and runs 80 rounds per 64-byte block.
// an end mark makes the front end emit 9 to 72 pad and length bytes, one per cycle unless
// the queue is full, with item_stall high; the five digest words follow the last compression.
// reset clears all control state and loads the initial chaining value at once.
// digest_stall holds the output register; the core keeps working until it needs it.
`timescale 1ns / 1ps

module sha1_stream_hash import sha1s_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    digest_valid,
    input  logic    digest_stall,
    output result_t digest
);

    qpush_t q_wr;
    qent_t  q_head;
    logic   q_full;
    logic   q_avail;
    logic   q_rd;

    sha1s_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_wr       (q_wr)
    );

    sha1s_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .rd    (q_rd),
        .head  (q_head),
        .avail (q_avail),
        .full  (q_full)
    );

    sha1s_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_avail      (q_avail),
        .q_rd         (q_rd),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    // the front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_wr.push && q_full))
        else $error("op pushed into full queue");

    // digest words follow each other without a gap once the first is out
    a_word_follow: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_stall && !digest.last_word |=>
        digest_valid && (digest.word_index == $past(digest.word_index) + 3'd1))
        else $error("digest word missing or out of order");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_word == (digest.word_index == LAST_INDEX)))
        else $error("last_word disagrees with word_index");

    // an end mark cannot be taken while pad bytes are still being issued
    a_stall_pad: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.kind == KIND_END) |=> item_stall)
        else $error("input taken during padding");

endmodule

// ===== src/sha1s_front.sv =====
// front end: takes input beats, counts message bits and expands an end mark
// into pad bytes, length bytes and a finish op; depends on sha1s_pkg
`timescale 1ns / 1ps

module sha1s_front import sha1s_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_stall,
    input  item_t  item,
    input  logic   q_full,
    output qpush_t q_wr
);

    localparam logic [1:0] FR_IDLE = 2'd0;
    localparam logic [1:0] FR_PAD  = 2'd1;
    localparam logic [1:0] FR_LEN  = 2'd2;
    localparam logic [1:0] FR_FIN  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] count_reg, count_next;
    logic [63:0] len_reg, len_next;
    logic [2:0]  lcnt_reg, lcnt_next;
    logic        accept;
    logic [5:0]  pos_inc;

    assign item_stall = (state_reg != FR_IDLE) || q_full;
    assign accept     = item_valid && !item_stall;
    assign pos_inc    = pos_reg + 6'd1;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        len_next   = len_reg;
        lcnt_next  = lcnt_reg;
        q_wr       = '{push: 1'b0, ent: '{op: OP_BYTE, value: 8'h00}};
        unique case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    q_wr.push = 1'b1;
                    pos_next  = pos_inc;
                    if (item.kind == KIND_DATA)
                    begin
                        q_wr.ent.value = item.data_byte;
                        count_next     = count_reg + 64'd8;
                    end
                    else
                    begin
                        q_wr.ent.value = PAD_MARK;
                        len_next       = count_reg;
                        count_next     = '0;
                        lcnt_next      = '0;
                        state_next     = (pos_inc == LEN_POS) ? FR_LEN : FR_PAD;
                    end
                end
            end
            FR_PAD:
            begin
                if (!q_full)
                begin
                    q_wr.push = 1'b1;
                    pos_next  = pos_inc;
                    if (pos_inc == LEN_POS)
                    begin
                        state_next = FR_LEN;
                    end
                end
            end
            FR_LEN:
            begin
                // bit length goes out most significant byte first
                if (!q_full)
                begin
                    q_wr.push      = 1'b1;
                    q_wr.ent.value = len_reg[63:56];
                    len_next       = {len_reg[55:0], 8'h00};
                    pos_next       = pos_inc;
                    lcnt_next      = lcnt_reg + 3'd1;
                    if (lcnt_reg == 3'd7)
                    begin
                        state_next = FR_FIN;
                    end
                end
            end
            default:
            begin
                if (!q_full)
                begin
                    q_wr.push   = 1'b1;
                    q_wr.ent.op = OP_FINISH;
                    state_next  = FR_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            pos_reg   <= '0;
            count_reg <= '0;
            lcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            lcnt_reg  <= lcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule

// ===== src/sha1s_fifo.sv =====
// short op queue between the front end and the compression core
// depends on sha1s_pkg
`timescale 1ns / 1ps

module sha1s_fifo import sha1s_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  qpush_t wr,
    input  logic   rd,
    output qent_t  head,
    output logic   avail,
    output logic   full
);

    qent_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, wp_next;
    logic [QPTR_W-1:0] rp_reg, rp_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign avail = (cnt_reg != '0);
    assign head  = mem_reg[rp_reg];
    assign do_wr = wr.push && !full;
    assign do_rd = rd && avail;

    always_comb
    begin
        wp_next  = do_wr ? wp_reg + QPTR_W'(1) : wp_reg;
        rp_next  = do_rd ? rp_reg + QPTR_W'(1) : rp_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr.ent;
        end
    end

endmodule

// ===== src/sha1s_core.sv =====
// back end: packs bytes into the message window, runs 80 rounds per block,
// folds into the chaining value and streams the digest; depends on sha1s_pkg
`timescale 1ns / 1ps

module sha1s_core import sha1s_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  qent_t   q_head,
    input  logic    q_avail,
    output logic    q_rd,
    output logic    digest_valid,
    input  logic    digest_stall,
    output result_t digest
);

    localparam logic [1:0] BK_IDLE  = 2'd0;
    localparam logic [1:0] BK_ROUND = 2'd1;
    localparam logic [1:0] BK_ADD   = 2'd2;
    localparam logic [1:0] BK_OUT   = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    logic [31:0] win_reg [BLOCK_WORDS];
    logic [31:0] chain_reg [DIGEST_WORDS];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;

    logic        take_byte;
    logic [1:0]  lane;
    logic [3:0]  widx;
    logic [31:0] merged;
    logic [31:0] sched_mix;
    logic [31:0] sched_new;
    logic [31:0] t_sum;
    logic        out_load;

    // bytes may also drain during the chain add, a finish op may not
    assign q_rd      = q_avail && ((state_reg == BK_IDLE) ||
                                   ((state_reg == BK_ADD) && (q_head.op == OP_BYTE)));
    assign take_byte = q_rd && (q_head.op == OP_BYTE);
    assign lane      = pos_reg[1:0];
    assign widx      = pos_reg[5:2];
    assign merged    = (lane == 2'd0) ? {q_head.value, 24'h000000}
                     : (win_reg[widx] | ({24'h000000, q_head.value} << {~lane, 3'b000}));

    // rolling schedule: window slot 0 always holds w for the current round
    assign sched_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign sched_new = {sched_mix[30:0], sched_mix[31]};
    assign t_sum     = {a_reg[26:0], a_reg[31:27]} + round_f(round_reg, b_reg, c_reg, d_reg)
                     + e_reg + round_k(round_reg) + win_reg[0];

    assign out_load  = (state_reg == BK_OUT) && (!out_valid_reg || !digest_stall);

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        oidx_next      = oidx_reg;
        pos_next       = take_byte ? pos_reg + 6'd1 : pos_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !digest_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_rd)
                begin
                    if (q_head.op == OP_FINISH)
                    begin
                        state_next = BK_OUT;
                        oidx_next  = '0;
                    end
                    else if (pos_reg == LAST_POS)
                    begin
                        state_next = BK_ROUND;
                        round_next = '0;
                    end
                end
            end
            BK_ROUND:
            begin
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = BK_ADD;
                end
            end
            BK_ADD:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    oidx_next      = oidx_reg + 3'd1;
                    if (oidx_reg == LAST_INDEX)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pos_reg       <= '0;
            round_reg     <= '0;
            oidx_reg      <= '0;
            out_valid_reg <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            e_reg         <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            round_reg     <= round_next;
            oidx_reg      <= oidx_next;
            out_valid_reg <= out_valid_next;
            if ((state_reg == BK_IDLE) && take_byte && (pos_reg == LAST_POS))
            begin
                a_reg <= chain_reg[0];
                b_reg <= chain_reg[1];
                c_reg <= chain_reg[2];
                d_reg <= chain_reg[3];
                e_reg <= chain_reg[4];
            end
            else if (state_reg == BK_ROUND)
            begin
                a_reg <= t_sum;
                b_reg <= a_reg;
                c_reg <= {b_reg[1:0], b_reg[31:2]};
                d_reg <= c_reg;
                e_reg <= d_reg;
            end
            if (state_reg == BK_ADD)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
            else if (out_load && (oidx_reg == LAST_INDEX))
            begin
                // last word is in the output register, start the next message fresh
                for (int i = 0; i < DIGEST_WORDS; i++)
                begin
                    chain_reg[i] <= init_hash(3'(i));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_ROUND)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[BLOCK_WORDS - 1] <= sched_new;
        end
        else if (take_byte)
        begin
            win_reg[widx] <= merged;
        end
        if (out_load)
        begin
            out_reg.digest_word <= chain_reg[oidx_reg];
            out_reg.word_index  <= oidx_reg;
            out_reg.last_word   <= (oidx_reg == LAST_INDEX);
        end
    end

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

endmodule
